@@ hw/rtl/layer_blend_compositor_macros.svh @@
// Assertion macros shared by the layer blend compositor RTL.
`ifndef LAYER_BLEND_COMPOSITOR_MACROS_SVH
`define LAYER_BLEND_COMPOSITOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define LBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// The condition must never be true at a clock edge outside reset.
`define LBC_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define LBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LBC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ hw/rtl/lbc_pkg.sv @@
// Types and constants shared by the layer blend compositor modules.
package lbc_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned AlphaW = 16;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_MULTIPLY = 3'd1,
    MODE_SCREEN   = 3'd2,
    MODE_OVERLAY  = 3'd3,
    MODE_ADD      = 3'd4,
    MODE_SUBTRACT = 3'd5
  } mode_e;

  typedef struct packed {
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [AlphaW-1:0] eff_alpha;
    mode_e             mode;
    logic              skip;
    logic              first;
    logic              last;
  } item_t;

endpackage

@@ hw/rtl/lbc_front.sv @@
// Front end: computes the effective alpha and classifies each incoming layer.
module lbc_front import lbc_pkg::*; (
  input  logic [ChanW-1:0] src_red_i,
  input  logic [ChanW-1:0] src_green_i,
  input  logic [ChanW-1:0] src_blue_i,
  input  logic [ChanW-1:0] src_alpha_i,
  input  logic [ChanW-1:0] layer_opacity_i,
  input  logic [2:0]       blend_mode_i,
  input  logic             layer_visible_i,
  input  logic             first_layer_i,
  input  logic             last_layer_i,
  output item_t            item_o
);

  logic [AlphaW-1:0] eff;
  mode_e             mode;

  assign eff = AlphaW'(src_alpha_i) * AlphaW'(layer_opacity_i);

  always_comb begin
    unique case (blend_mode_i) inside
      MODE_MULTIPLY, MODE_SCREEN, MODE_OVERLAY, MODE_ADD, MODE_SUBTRACT: begin
        mode = mode_e'(blend_mode_i);
      end
      default: begin
        mode = MODE_NORMAL;
      end
    endcase
  end

  always_comb begin
    item_o.red       = src_red_i;
    item_o.green     = src_green_i;
    item_o.blue      = src_blue_i;
    item_o.eff_alpha = eff;
    item_o.mode      = mode;
    item_o.skip      = !layer_visible_i || (eff == '0);
    item_o.first     = first_layer_i;
    item_o.last      = last_layer_i;
  end

endmodule

@@ hw/rtl/lbc_queue.sv @@
// Short queue of classified layers between the front end and the blend engine.
`include "layer_blend_compositor_macros.svh"
module lbc_queue import lbc_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  deq_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  item_t            slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr_en;
  logic             rd_en;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = deq_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  `LBC_NEVER(count_in_range, clk_i, rst_ni, count_q > CntW'(DEPTH), "Queue count exceeds depth.")
  `LBC_NEVER(no_deq_when_empty, clk_i, rst_ni, deq_i && (count_q == '0), "Dequeue from empty queue.")

endmodule

@@ hw/rtl/lbc_back.sv @@
// Blend engine: applies each queued layer to the accumulator and holds the result.
`include "layer_blend_compositor_macros.svh"
module lbc_back import lbc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  item_t            item_i,
  output logic             deq_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [ChanW-1:0] out_red_o,
  output logic [ChanW-1:0] out_green_o,
  output logic [ChanW-1:0] out_blue_o,
  output logic [ChanW-1:0] out_alpha_o
);

  localparam int unsigned Lanes      = 3;
  localparam int unsigned ProdW      = 2 * ChanW;
  localparam int unsigned ScaleW     = ChanW + AlphaW;
  localparam int unsigned RecipShift = 32;
  localparam int unsigned RecipW     = 17;
  localparam int unsigned RecipProdW = ScaleW + RecipW;
  localparam int unsigned RemW       = ScaleW + 2;
  localparam int unsigned ResW       = ChanW + 2;
  localparam logic [ChanW-1:0]  ChanMax    = '1;
  localparam logic [RemW-1:0]   FullAlpha  = RemW'(65025);
  localparam logic [RecipW-1:0] RecipAlpha = RecipW'(66051);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_RECIP = 6'b010000,
    ST_APPLY = 6'b100000
  } state_e;

  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW+ChanW-1:0] t;
    logic [ChanW-1:0]       q0;
    logic [ProdW:0]         r;
    t  = {x, ChanW'(0)} + (ProdW + ChanW)'(x);
    q0 = t[ProdW+ChanW-1:ProdW];
    r  = (ProdW + 1)'(x) - {1'b0, q0, ChanW'(0)} + (ProdW + 1)'(q0);
    return q0 + ChanW'(r >= (ProdW + 1)'(ChanMax));
  endfunction

  state_e           state_q, state_d;
  item_t            work_q, work_d;
  logic [ChanW-1:0] acc_q [Lanes];
  logic [ChanW-1:0] acc_d [Lanes];
  logic [ChanW-1:0] acc_clr [Lanes];
  logic             covered_q, covered_d, cov_clr;
  logic [ProdW-1:0] prod_q [Lanes];
  logic [ProdW-1:0] prod_d [Lanes];
  logic [ChanW-1:0] diff_q [Lanes];
  logic [ChanW-1:0] diff_d [Lanes];
  logic             neg_q [Lanes];
  logic             neg_d [Lanes];
  logic [ScaleW-1:0] p_q [Lanes];
  logic [ScaleW-1:0] p_d [Lanes];
  logic [ChanW-1:0] q0_q [Lanes];
  logic [ChanW-1:0] q0_d [Lanes];
  logic [ChanW-1:0] res [Lanes];
  logic [ChanW-1:0] src [Lanes];
  logic [ChanW-1:0] item_src [Lanes];
  logic             out_valid_q, out_valid_d;
  logic [ChanW-1:0] out_q [Lanes];
  logic [ChanW-1:0] out_d [Lanes];
  logic             out_cov_q, out_cov_d;
  logic             out_free;
  logic             emit;

  assign src[0]      = work_q.red;
  assign src[1]      = work_q.green;
  assign src[2]      = work_q.blue;
  assign item_src[0] = item_i.red;
  assign item_src[1] = item_i.green;
  assign item_src[2] = item_i.blue;
  assign out_free    = !out_valid_q || pop_i;
  assign cov_clr     = item_i.first ? 1'b0 : covered_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      acc_clr[l] = item_i.first ? '0 : acc_q[l];
    end
  end

  // Per-lane datapath for the blend, difference, scaling and rounding steps.
  always_comb begin
    logic [ChanW-1:0]  a, b, q, bl;
    logic [ProdW-1:0]  m;
    logic [ChanW:0]    sum;
    logic [RecipProdW-1:0] t;
    logic [RemW-1:0]   rem, rem_f;
    logic              ge;
    logic [ChanW:0]    qq;
    logic [ResW-1:0]   r;
    for (int l = 0; l < Lanes; l++) begin
      if ((work_q.mode == MODE_SCREEN) || ((work_q.mode == MODE_OVERLAY) && acc_q[l][ChanW-1])) begin
        a = ChanMax - src[l];
        b = ChanMax - acc_q[l];
      end else begin
        a = src[l];
        b = acc_q[l];
      end
      m = ProdW'(a) * ProdW'(b);
      prod_d[l] = (work_q.mode == MODE_OVERLAY) ? {m[ProdW-2:0], 1'b0} : m;

      q   = div255(prod_q[l]);
      sum = (ChanW + 1)'(src[l]) + (ChanW + 1)'(acc_q[l]);
      case (work_q.mode)
        MODE_MULTIPLY: bl = q;
        MODE_SCREEN:   bl = ChanMax - q;
        MODE_OVERLAY:  bl = acc_q[l][ChanW-1] ? ChanMax - q : q;
        MODE_ADD:      bl = sum[ChanW] ? ChanMax : sum[ChanW-1:0];
        MODE_SUBTRACT: bl = (acc_q[l] > src[l]) ? acc_q[l] - src[l] : '0;
        default:       bl = src[l];
      endcase
      neg_d[l]  = bl < acc_q[l];
      diff_d[l] = (bl < acc_q[l]) ? acc_q[l] - bl : bl - acc_q[l];

      p_d[l] = ScaleW'(diff_q[l]) * ScaleW'(work_q.eff_alpha);

      t       = RecipProdW'(p_q[l]) * RecipProdW'(RecipAlpha);
      q0_d[l] = t[RecipShift+ChanW-1:RecipShift];

      rem   = RemW'(p_q[l]) - (RemW'(q0_q[l]) << 16) + (RemW'(q0_q[l]) << 9)
            - RemW'(q0_q[l]);
      ge    = rem >= FullAlpha;
      rem_f = ge ? rem - FullAlpha : rem;
      qq    = (ChanW + 1)'(q0_q[l]) + (ChanW + 1)'(ge);
      if (neg_q[l]) begin
        r = ResW'(acc_q[l]) - ResW'(qq) - ResW'(rem_f != '0);
      end else begin
        r = ResW'(acc_q[l]) + ResW'(qq);
      end
      if (r[ResW-1]) begin
        res[l] = '0;
      end else if (r[ChanW]) begin
        res[l] = ChanMax;
      end else begin
        res[l] = r[ChanW-1:0];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    acc_d       = acc_q;
    covered_d   = covered_q;
    deq_o       = 1'b0;
    emit        = 1'b0;
    out_d       = out_q;
    out_cov_d   = out_cov_q;
    out_valid_d = out_valid_q && !pop_i;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (item_i.skip) begin
            if (!item_i.last || out_free) begin
              deq_o     = 1'b1;
              acc_d     = acc_clr;
              covered_d = cov_clr;
              if (item_i.last) begin
                emit      = 1'b1;
                out_d     = acc_clr;
                out_cov_d = cov_clr;
              end
            end
          end else begin
            deq_o     = 1'b1;
            acc_d     = acc_clr;
            covered_d = cov_clr;
            work_d    = item_i;
            state_d   = ST_MUL;
          end
        end
      end
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_RECIP;
      ST_RECIP: state_d = ST_APPLY;
      ST_APPLY: begin
        if (!work_q.last || out_free) begin
          acc_d     = res;
          covered_d = 1'b1;
          state_d   = ST_IDLE;
          if (work_q.last) begin
            emit      = 1'b1;
            out_d     = res;
            out_cov_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      covered_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < Lanes; l++) begin
        acc_q[l] <= '0;
      end
    end else begin
      state_q     <= state_d;
      covered_q   <= covered_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    prod_q    <= prod_d;
    diff_q    <= diff_d;
    neg_q     <= neg_d;
    p_q       <= p_d;
    q0_q      <= q0_d;
    out_q     <= out_d;
    out_cov_q <= out_cov_d;
  end

  assign empty_o     = !out_valid_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];
  assign out_alpha_o = out_cov_q ? ChanMax : '0;

  `LBC_ASSERT(emit_fills_output, clk_i, rst_ni, (state_q == ST_APPLY && work_q.last && out_free) |=> out_valid_q, "Blended result not presented.")
  `LBC_ASSERT(blend_starts_on_deq, clk_i, rst_ni, (state_q == ST_IDLE && state_d == ST_MUL) |-> (deq_o && q_valid_i), "Blend started without a queued layer.")
  `LBC_ASSERT(apply_sets_coverage, clk_i, rst_ni, (state_q == ST_APPLY && state_d == ST_IDLE) |=> covered_q, "Coverage not set after a blended layer.")

endmodule

@@ hw/rtl/layer_blend_compositor.sv @@
// Top level of the layer blend compositor: front end, layer queue and blend engine.
// Layers of one pixel position arrive bottom first; a layer with first_layer set clears the
// accumulator and coverage beforehand, and one with last_layer set leaves the composited pixel
// (alpha 255 if any layer contributed, else 0) in the result register. A skipped layer
// (invisible, or zero alpha times opacity) is dequeued without entering the blend steps; a
// blended layer passes through the multiply, divide-by-255, alpha scaling, reciprocal rounding
// and apply steps, which each depend on the accumulator left by the previous layer. Up to
// QUEUE_DEPTH classified layers wait between the front end and the engine, and a finished pixel
// waits in its own register, so a full transaction is only refused when the queue is full.
module layer_blend_compositor import lbc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [ChanW-1:0] src_red_i,
  input  logic [ChanW-1:0] src_green_i,
  input  logic [ChanW-1:0] src_blue_i,
  input  logic [ChanW-1:0] src_alpha_i,
  input  logic [ChanW-1:0] layer_opacity_i,
  input  logic [2:0]       blend_mode_i,
  input  logic             layer_visible_i,
  input  logic             first_layer_i,
  input  logic             last_layer_i,
  output logic             empty,
  input  logic             pop,
  output logic [ChanW-1:0] out_red_o,
  output logic [ChanW-1:0] out_green_o,
  output logic [ChanW-1:0] out_blue_o,
  output logic [ChanW-1:0] out_alpha_o
);

  item_t front_item;
  item_t head_item;
  logic  head_valid;
  logic  head_deq;

  lbc_front u_front (
    .src_red_i       (src_red_i),
    .src_green_i     (src_green_i),
    .src_blue_i      (src_blue_i),
    .src_alpha_i     (src_alpha_i),
    .layer_opacity_i (layer_opacity_i),
    .blend_mode_i    (blend_mode_i),
    .layer_visible_i (layer_visible_i),
    .first_layer_i   (first_layer_i),
    .last_layer_i    (last_layer_i),
    .item_o          (front_item)
  );

  lbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .deq_i   (head_deq),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  lbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (head_valid),
    .item_i      (head_item),
    .deq_o       (head_deq),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o)
  );

endmodule
